[sv/cdq_pkg.sv]
`default_nettype none
package cdq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_PEEK_FRONT = 3'd4,
      MODE_PEEK_BACK  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   // one access to the store
   typedef struct packed {
      logic              we;
      logic              re;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

endpackage
`default_nettype wire

[sv/cdq_ram.sv]
`default_nettype none
module cdq_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[sv/cdq_ctrl.sv]
`default_nettype none
module cdq_ctrl
   import cdq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [2:0]          req_mode,
   input  wire logic [DATA_W-1:0]   req_value,
   output mem_req_type              mem_req,
   input  wire logic [DATA_W-1:0]   mem_rdata,
   output logic                     rsp_valid,
   output logic [DATA_W-1:0]        rsp_data,
   output logic [1:0]               rsp_status,
   output logic [CNT_W-1:0]         rsp_occupancy
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   logic             rd_ff, rd_in;

   logic             accept;
   logic             full, empty;
   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign tail_inc = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? IDX_W'(DEPTH - 1) : tail_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rd_ff     <= rd_in;
   end

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      status_in       = status_ff;
      rd_in           = rd_ff;
      mem_req.we      = 1'b0;
      mem_req.re      = 1'b0;
      mem_req.addr    = head_ff;
      mem_req.wdata   = req_value;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_RESP;
               status_in = STAT_DONE;
               rd_in     = 1'b0;
               case (req_mode)
                  MODE_PUSH_FRONT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        head_in      = head_dec;
                        count_in     = count_ff + 1'b1;
                        mem_req.we   = 1'b1;
                        mem_req.addr = head_dec;
                     end
                  end
                  MODE_PUSH_BACK: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        tail_in      = tail_inc;
                        count_in     = count_ff + 1'b1;
                        mem_req.we   = 1'b1;
                        mem_req.addr = tail_ff;
                     end
                  end
                  MODE_POP_FRONT, MODE_PEEK_FRONT: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        rd_in        = 1'b1;
                        mem_req.re   = 1'b1;
                        mem_req.addr = head_ff;
                        if (req_mode == MODE_POP_FRONT) begin
                           head_in  = head_inc;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  MODE_POP_BACK, MODE_PEEK_BACK: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        rd_in        = 1'b1;
                        mem_req.re   = 1'b1;
                        mem_req.addr = tail_dec;
                        if (req_mode == MODE_POP_BACK) begin
                           tail_in  = tail_dec;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     // unused code: deque unchanged, done status
                  end
               endcase
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_RESP);
   assign rsp_data      = rd_ff ? mem_rdata : '0;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = count_ff;

endmodule
`default_nettype wire

[sv/circular_deque.sv]
// circular_deque: double-ended queue of signed 32-bit words, DEPTH entries.
//
// Request side: drive req_mode / req_value and raise start; the transaction
// is taken at the rising edge where start is high and busy is low.
// Modes: push front, push back, pop front, pop back, peek front, peek back.
// Response side: one transaction per request. rsp_valid is high for exactly
// one cycle, the cycle after the request is taken, carrying rsp_data,
// rsp_status (done / full / empty) and rsp_occupancy after the operation.
// The receiver cannot stall; it must take the response in that cycle.
// The response comes in the cycle after accept. A new request cannot be
// taken during the response cycle: busy is high then because the store
// is a single-port RAM with a registered read, so a read issued at accept
// returns in the next cycle.
// Reset (synchronous, active high) empties the deque: head, tail and count
// go to zero. Store contents are not cleared; only occupied entries are read.
// Push on full returns status full, pop/peek on empty returns data 0 with
// status empty; the deque is unchanged in both cases.
`default_nettype none
module circular_deque
   import cdq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_mode,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_data,
   output logic [1:0]              rsp_status,
   output logic [CNT_W-1:0]        rsp_occupancy
);

   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rdata;
   logic [DATA_W-1:0] rsp_data_raw;

   // sequencing, pointers and occupancy
   cdq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .mem_req       (mem_req),
      .mem_rdata     (mem_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data_raw),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   // word store, one access per cycle, registered read
   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .re    (mem_req.re),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   assign rsp_data = rsp_data_raw;

`ifndef SYNTHESIS
   // every accepted request answers in the next cycle
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("response missing after accepted request");

   // responses are single-cycle strobes
   a_resp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // full rejection only with a full store
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> (rsp_occupancy == CNT_W'(DEPTH)))
      else $error("full status with store not full");

   // empty rejection: no data, no words
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_EMPTY) |-> (rsp_occupancy == '0 && rsp_data == '0))
      else $error("empty status with data or words present");

   // occupancy never exceeds the store depth
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CNT_W'(DEPTH)))
      else $error("occupancy beyond depth");
`endif

endmodule
`default_nettype wire
